@@ rtl/core/vcsa_pkg.sv @@
// types and constants shared by the voice channel stealing allocator
package vcsa_pkg;

  localparam int unsigned EntityW = 13;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned LenW    = 24;
  localparam int unsigned NowW    = 31;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ChanW   = 6;

  localparam logic signed [TimeW-1:0] LifeStart = 32'sh7fff_ffff;
  localparam logic [SlotW-1:0]        SlotAny   = 4'hf;
  localparam logic [SlotW-1:0]        SlotNone  = 4'h0;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STOP  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [EntityW-1:0] entity;
    logic [SlotW-1:0]   slot;
    logic [LenW-1:0]    sound_length;
    logic [NowW-1:0]    now;
    logic               audible;
  } req_t;

  typedef struct packed {
    logic [EntityW-1:0] owner_entity;
    logic [SlotW-1:0]   owner_slot;
    logic [TimeW-1:0]   end_time;
    logic               voice_active;
  } entry_t;

  typedef struct packed {
    logic                    found;
    logic                    lock;
    logic                    was_active;
    logic [ChanW-1:0]        pick;
    logic signed [TimeW-1:0] best;
  } scan_t;

endpackage

@@ rtl/core/vcsa_eval.sv @@
// per-entry selection step of the channel scan
module vcsa_eval (
  input  vcsa_pkg::req_t                  req_i,
  input  vcsa_pkg::entry_t                entry_i,
  input  logic [vcsa_pkg::EntityW-1:0]    player_i,
  input  logic [vcsa_pkg::ChanW-1:0]      idx_i,
  input  vcsa_pkg::scan_t                 cur_i,
  output vcsa_pkg::scan_t                 nxt_o
);
  import vcsa_pkg::*;

  logic signed [TimeW-1:0] life;
  logic                    same_owner;
  logic                    exact;
  logic                    override;
  logic                    protect;

  assign life       = signed'(entry_i.end_time - {1'b0, req_i.now});
  assign same_owner = (entry_i.owner_entity == req_i.entity);
  assign exact      = same_owner && (entry_i.owner_slot == req_i.slot);
  assign override   = (req_i.slot != SlotNone) && same_owner &&
                      ((entry_i.owner_slot == req_i.slot) || (req_i.slot == SlotAny));
  assign protect    = (entry_i.owner_entity == player_i) && (req_i.entity != player_i) &&
                      entry_i.voice_active;

  always_comb begin
    nxt_o = cur_i;
    if (!cur_i.lock) begin
      if (req_i.mode == MODE_STOP) begin
        if (exact) begin
          nxt_o.found      = 1'b1;
          nxt_o.lock       = 1'b1;
          nxt_o.pick       = idx_i;
          nxt_o.was_active = entry_i.voice_active;
        end
      end else if (override) begin
        nxt_o.found      = 1'b1;
        nxt_o.lock       = 1'b1;
        nxt_o.pick       = idx_i;
        nxt_o.was_active = entry_i.voice_active;
      end else if (!protect && (life < cur_i.best)) begin
        nxt_o.found      = 1'b1;
        nxt_o.best       = life;
        nxt_o.pick       = idx_i;
        nxt_o.was_active = entry_i.voice_active;
      end
    end
  end

endmodule

@@ rtl/core/voice_channel_stealing_allocator_core.sv @@
// voice channel stealing allocator: top level with channel table and control
// Requests are served one at a time. After a request is taken the channel table
// is read one entry per cycle from a single-port memory, and any chosen entry
// is written back before the result is presented; the next request is taken
// as soon as the previous result has been loaded into the output register,
// even while that result is still stalled. A start request overrides a
// matching entity slot or steals the entry with the least remaining life,
// keeping the listener's active voices; a stop request silences the first
// exact owner and slot match. The table reads as all zero after reset, with
// no clearing pass.
module voice_channel_stealing_allocator_core #(
  parameter int unsigned DYNAMIC_CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vcsa_pkg::EntityW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [vcsa_pkg::EntityW-1:0]  entity_i,
  input  logic signed [vcsa_pkg::SlotW-1:0] entity_channel_i,
  input  logic [vcsa_pkg::LenW-1:0]     sound_length_i,
  input  logic [vcsa_pkg::NowW-1:0]     now_i,
  input  logic                          audible_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [vcsa_pkg::ChanW-1:0]    channel_index_o,
  output logic                          stole_active_o
);
  import vcsa_pkg::*;

  localparam int unsigned IdxW = (DYNAMIC_CHANNELS > 1) ? $clog2(DYNAMIC_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(DYNAMIC_CHANNELS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WB   = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [EntityW-1:0]    player_q;
  req_t                  req_q;
  logic [CntW-1:0]       rd_cnt_q;
  logic                  rvld_q;
  logic [ChanW-1:0]      ridx_q;
  logic                  rent_vld_q;
  entry_t                rdata_q;
  scan_t                 scan_q, scan_d;
  logic [DYNAMIC_CHANNELS-1:0] ent_vld_q;
  entry_t                mem_q [DYNAMIC_CHANNELS];

  logic                  in_acc;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  entry_t                wr_data;
  entry_t                rd_entry;
  logic                  out_load;
  logic                  out_valid_q;
  logic                  found_q;
  logic [ChanW-1:0]      chan_q;
  logic                  stole_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // table read, one entry per cycle
  assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < CntW'(DYNAMIC_CHANNELS));
  assign rd_addr = rd_cnt_q[IdxW-1:0];

  // entries never written read as zero
  assign rd_entry = rent_vld_q ? rdata_q : '0;

  vcsa_eval u_eval (
    .req_i    (req_q),
    .entry_i  (rd_entry),
    .player_i (player_q),
    .idx_i    (ridx_q),
    .cur_i    (scan_q),
    .nxt_o    (scan_d)
  );

  // write-back of the chosen entry
  assign wr_en   = (state_q == ST_WB) && scan_q.found;
  assign wr_addr = scan_q.pick[IdxW-1:0];
  always_comb begin
    wr_data.owner_entity = req_q.entity;
    wr_data.owner_slot   = req_q.slot;
    if ((req_q.mode == MODE_START) && req_q.audible) begin
      wr_data.voice_active = 1'b1;
      wr_data.end_time     = {1'b0, req_q.now} + {{(TimeW-LenW){1'b0}}, req_q.sound_length};
    end else begin
      wr_data.voice_active = 1'b0;
      wr_data.end_time     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (!rd_en && !rvld_q) state_d = ST_WB;
      ST_WB:   state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      player_q    <= '0;
      rd_cnt_q    <= '0;
      rvld_q      <= 1'b0;
      rent_vld_q  <= 1'b0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        player_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        rd_cnt_q <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
      end
      rvld_q <= rd_en;
      if (rd_en) begin
        rent_vld_q <= ent_vld_q[rd_addr];
      end
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.mode         <= mode_e'(mode_i);
      req_q.entity       <= entity_i;
      req_q.slot         <= entity_channel_i;
      req_q.sound_length <= sound_length_i;
      req_q.now          <= now_i;
      req_q.audible      <= audible_i;
      scan_q.found       <= 1'b0;
      scan_q.lock        <= 1'b0;
      scan_q.was_active  <= 1'b0;
      scan_q.pick        <= '0;
      scan_q.best        <= LifeStart;
    end else if (rvld_q) begin
      scan_q <= scan_d;
    end
    if (rd_en) begin
      ridx_q <= ChanW'(rd_addr);
    end
    if (out_load) begin
      found_q <= scan_q.found;
      chan_q  <= scan_q.found ? scan_q.pick : '0;
      stole_q <= scan_q.found && scan_q.was_active;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign channel_index_o = chan_q;
  assign stole_active_o  = stole_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result presented outside completion");

  a_wb_after_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |-> (!rvld_q && !rd_en))
    else $error("write-back while table reads outstanding");

  a_no_find_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (channel_index_o == '0 && !stole_active_o))
    else $error("empty result carries nonzero fields");

  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> (state_q == ST_IDLE || state_q == ST_SCAN))
    else $error("illegal exit from idle");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ({1'b0, scan_q.pick} < (ChanW+1)'(DYNAMIC_CHANNELS)))
    else $error("write-back index beyond table");

endmodule
